// ===== rtl/core/u8cpf_pkg.sv =====
package u8cpf_pkg;

	localparam int POS_W       = 17;
	localparam int LEN_W       = 16;
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;

	// largest character index taken; wider requests clamp to it
	localparam logic [32:0] MAX_LEN = 33'd65535;

	typedef enum logic {
		DIR_FWD = 1'b0,
		DIR_BWD = 1'b1
	} dir_t;

	typedef struct packed {
		dir_t             mode;
		logic             first;
		logic [LEN_W-1:0] target_index;
		logic [LEN_W-1:0] byte_count;
		logic [7:0]       data_byte;
		logic             last;
	} beat_t;

	typedef struct packed {
		dir_t             direction;
		logic [LEN_W-1:0] index_left;
		logic [LEN_W-1:0] byte_pos;
		logic [1:0]       skip_left;
		logic [LEN_W-1:0] last_start_pos;
		logic             answered;
		logic [LEN_W-1:0] answer;
		logic [LEN_W-1:0] total_len;
	} state_t;

	localparam state_t STATE_RST = '{
		direction:      DIR_FWD,
		index_left:     '0,
		byte_pos:       '0,
		skip_left:      '0,
		last_start_pos: '0,
		answered:       1'b0,
		answer:         '0,
		total_len:      '0
	};

	// bytes that follow a lead byte in its encoding
	function automatic logic [1:0] enc_ext(input logic [7:0] b);
		logic [1:0] ext;
		if (b < 8'hC0) begin
			ext = 2'd0;
		end else if (b < 8'hE0) begin
			ext = 2'd1;
		end else if (b < 8'hF0) begin
			ext = 2'd2;
		end else begin
			ext = 2'd3;
		end
		return ext;
	endfunction

endpackage

// ===== rtl/core/u8cpf_step.sv =====
module u8cpf_step (
	input  u8cpf_pkg::beat_t                    beat,
	input  u8cpf_pkg::state_t                   state,
	output u8cpf_pkg::state_t                   nxt,
	output logic [u8cpf_pkg::POS_W-1:0]         position
);
	import u8cpf_pkg::*;

	state_t           ld;
	logic [LEN_W-1:0] off;
	logic [LEN_W-1:0] span_m1;
	logic [LEN_W-1:0] bad;
	logic [LEN_W-1:0] ext_w;
	logic [LEN_W-1:0] lo;
	logic [LEN_W-1:0] pending;
	logic [1:0]       ext;
	logic             is_lead;

	always_comb begin
		ld = state;
		if (beat.first) begin
			ld.direction      = beat.mode;
			ld.index_left     = ({17'd0, beat.target_index} > MAX_LEN) ?
			                    MAX_LEN[LEN_W-1:0] : beat.target_index;
			ld.total_len      = beat.byte_count;
			ld.byte_pos       = '0;
			ld.skip_left      = '0;
			ld.last_start_pos = beat.byte_count;
			ld.answered       = 1'b0;
			ld.answer         = '0;
		end

		nxt     = ld;
		ext     = enc_ext(beat.data_byte);
		ext_w   = {{(LEN_W-2){1'b0}}, ext};
		is_lead = beat.data_byte[7:6] != 2'b10;
		off     = '0;
		span_m1 = '0;
		bad     = '0;

		if (ld.byte_pos < ld.total_len) begin
			nxt.byte_pos = ld.byte_pos + 1'b1;
			if (!ld.answered) begin
				if (ld.direction == DIR_FWD) begin
					off = ld.byte_pos;
					if (ld.skip_left != 2'd0) begin
						nxt.skip_left = ld.skip_left - 1'b1;
					end else if (ld.index_left == '0) begin
						nxt.answer   = off;
						nxt.answered = 1'b1;
					end else begin
						nxt.index_left = ld.index_left - 1'b1;
						if (is_lead) begin
							nxt.skip_left = ext;
						end
					end
				end else begin
					off = ld.total_len - ld.byte_pos - 1'b1;
					if (is_lead) begin
						// continuations beyond what this lead claims count one each
						span_m1 = ld.last_start_pos - off - 1'b1;
						bad     = (span_m1 > ext_w) ? span_m1 - ext_w : '0;
						if (ld.index_left < bad) begin
							nxt.answer   = ld.last_start_pos - ld.index_left - 1'b1;
							nxt.answered = 1'b1;
						end else if (ld.index_left == bad) begin
							nxt.answer   = off;
							nxt.answered = 1'b1;
						end else begin
							nxt.index_left     = ld.index_left - bad - 1'b1;
							nxt.last_start_pos = off;
						end
					end
				end
			end
		end

		// stray continuations left at the low end still count as characters
		lo      = nxt.total_len - nxt.byte_pos;
		pending = nxt.last_start_pos - lo;
		if (nxt.direction == DIR_FWD) begin
			position = nxt.answered ? {1'b0, nxt.answer} : {1'b0, nxt.total_len};
		end else if (nxt.answered) begin
			position = {1'b0, nxt.answer};
		end else if (nxt.index_left < pending) begin
			position = {1'b0, nxt.last_start_pos - nxt.index_left - 1'b1};
		end else begin
			position = '1;
		end
	end

endmodule

// ===== rtl/core/utf8_char_position_finder_core.sv =====
// A result reaches m_tvalid through beat_s1 and then the output register
// once its tlast beat is accepted. Throughput: one byte beat per cycle while
// the sink does not stall, set by the state update on the string's counters.
// A stalled result holds in the output register while one more beat may enter.
// Reset (arst_n low) clears the valid flags and the string state at once.
module utf8_char_position_finder_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// target_index[15:0], byte_count[31:16], data_byte[39:32]
	input  logic [u8cpf_pkg::IN_TDATA_W-1:0]     s_tdata,
	// mode[0], first[1]
	input  logic [u8cpf_pkg::IN_TUSER_W-1:0]     s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// position[16:0], zero[23:17]
	output logic [u8cpf_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import u8cpf_pkg::*;

	beat_t            beat_s1;
	logic             valid_s1;
	state_t           state_q;
	state_t           state_nxt;
	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] pos_q;
	logic             m_valid_q;
	logic             adv;

	assign adv      = !m_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-POS_W){1'b0}}, pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_s1.mode         <= dir_t'(s_tuser[0]);
			beat_s1.first        <= s_tuser[1];
			beat_s1.target_index <= s_tdata[15:0];
			beat_s1.byte_count   <= s_tdata[31:16];
			beat_s1.data_byte    <= s_tdata[39:32];
			beat_s1.last         <= s_tlast;
		end
	end

	u8cpf_step u_step (
		.beat     (beat_s1),
		.state    (state_q),
		.nxt      (state_nxt),
		.position (pos_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= STATE_RST;
			m_valid_q <= 1'b0;
		end else if (adv) begin
			if (valid_s1) begin
				state_q <= state_nxt;
			end
			m_valid_q <= valid_s1 && beat_s1.last;
		end
	end

	// hold the result while the sink stalls
	always_ff @(posedge clk) begin
		if (adv && valid_s1 && beat_s1.last) begin
			pos_q <= pos_nxt;
		end
	end

endmodule

// ===== rtl/core/u8cpf_checker.sv =====
module u8cpf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [u8cpf_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import u8cpf_pkg::*;

	// a stalled result beat stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed under stall");

	// with the output register empty the input side must take a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// position is either a byte offset or the all-ones not-found code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_TDATA_W-1:POS_W] == '0) &&
		             (!m_tdata[POS_W-1] || (m_tdata[POS_W-1:0] == '1)))
		else $error("position out of range");

	assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid in reset");

endmodule

bind utf8_char_position_finder_core u8cpf_checker u_chk (.*);
